// File: rtl/beep_pattern_sequencer_defines.svh
// Assertion macros used by the beep pattern sequencer RTL.
`ifndef BEEP_PATTERN_SEQUENCER_DEFINES_SVH
`define BEEP_PATTERN_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define BPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("beep_pattern_sequencer: assertion failed");

// Same check, written as a condition that must hold at every edge outside reset.
`define BPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	`BPS_ASSERT(lbl, clk, rst_n, (cond))

`else

`define BPS_ASSERT(lbl, clk, rst_n, prop)
`define BPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

// File: rtl/bps_pkg.sv
// Package with widths, codes and types of the beep pattern sequencer.
package bps_pkg;

	localparam int FREQ_W = 16;
	localparam int CNT_W  = 16;
	localparam int REP_W  = 8;

	typedef logic [FREQ_W-1:0]       freq_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [REP_W-1:0] rep_t;

	// Request kinds on the input channel.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_CMD  = 1'b1;

	typedef struct packed {
		freq_t freq;
		rep_t  repeats;
		cnt_t  on_ticks;
		cnt_t  off_ticks;
	} cmd_t;

endpackage

// File: rtl/bps_if.sv
// Valid/ready channel interfaces for the beep pattern sequencer.
interface bps_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	bps_pkg::freq_t     tone_freq_in;
	bps_pkg::rep_t      repeat_count;
	bps_pkg::cnt_t      on_duration;
	bps_pkg::cnt_t      off_duration;

	modport source (
		output valid, func, tone_freq_in, repeat_count, on_duration, off_duration,
		input  ready
	);
	modport sink (
		input  valid, func, tone_freq_in, repeat_count, on_duration, off_duration,
		output ready
	);
endinterface

interface bps_out_if;
	logic               valid;
	logic               ready;
	bps_pkg::freq_t     tone_freq_out;
	logic               buzzer_on;

	modport source (
		output valid, tone_freq_out, buzzer_on,
		input  ready
	);
	modport sink (
		input  valid, tone_freq_out, buzzer_on,
		output ready
	);
endinterface

// File: rtl/beep_pattern_sequencer.sv
// Beep pattern sequencer: request decode, off/on state machine and result register.
//
// Usage: requests arrive on the item channel. A request with func set to the
// command code stores a new beep pattern in a one-deep pending slot; any other
// request is one time tick that advances the off/on state machine.
// Every accepted request produces exactly one result on the result channel:
// the frequency of the active pattern and the buzzer phase after the update.
// The result is valid in the cycle after acceptance.
// One request is taken per cycle while the receiver does not stall; the state
// update and the result are computed from the counter and repeat compares and
// decrements and selection, and the single result register sets that rate.
// When the receiver stalls, the result is held in the output register and the
// item channel stays ready only if that register is drained in the same cycle.
// Reset (arst_n low) clears the phase, the counter, both command slots and the
// result valid flag; the first tick after reset reports frequency 0 and off.
`include "beep_pattern_sequencer_defines.svh"

module beep_pattern_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	bps_in_if.sink     item,
	bps_out_if.source  result
);

	logic            phase_q;
	bps_pkg::cnt_t   cnt_q;
	logic            active_valid_q;
	bps_pkg::cmd_t   active_q;
	logic            pending_valid_q;
	bps_pkg::cmd_t   pending_q;

	logic            out_valid_q;
	bps_pkg::freq_t  out_freq_q;
	logic            out_buzzer_q;

	logic            phase_d;
	bps_pkg::cnt_t   cnt_d;
	logic            active_valid_d;
	bps_pkg::cmd_t   active_d;
	logic            pending_valid_d;
	bps_pkg::cmd_t   pending_d;

	logic            accept;
	logic            is_cmd;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign is_cmd     = (item.func == bps_pkg::FUNC_CMD);

	always_comb begin
		phase_d         = phase_q;
		cnt_d           = cnt_q;
		active_valid_d  = active_valid_q;
		active_d        = active_q;
		pending_valid_d = pending_valid_q;
		pending_d       = pending_q;
		if (is_cmd) begin
			pending_valid_d     = 1'b1;
			pending_d.freq      = item.tone_freq_in;
			pending_d.repeats   = item.repeat_count;
			pending_d.on_ticks  = item.on_duration;
			pending_d.off_ticks = item.off_duration;
		end else if (cnt_q != '0) begin
			cnt_d = cnt_q - bps_pkg::cnt_t'(1);
		end else if (!phase_q) begin
			if (active_valid_q) begin
				cnt_d   = active_q.on_ticks;
				phase_d = 1'b1;
			end else if (pending_valid_q) begin
				// Promotion only; the on phase starts on the next tick.
				active_valid_d  = 1'b1;
				active_d        = pending_q;
				pending_valid_d = 1'b0;
			end
		end else begin
			// End of an on phase: either another beep follows or the pattern is done.
			if (active_q.repeats > bps_pkg::rep_t'(1)) begin
				active_d.repeats = active_q.repeats - bps_pkg::rep_t'(1);
				cnt_d            = active_q.off_ticks;
			end else begin
				active_valid_d = 1'b0;
			end
			phase_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= 1'b0;
			cnt_q           <= '0;
			active_valid_q  <= 1'b0;
			active_q        <= '0;
			pending_valid_q <= 1'b0;
			pending_q       <= '0;
		end else if (accept) begin
			phase_q         <= phase_d;
			cnt_q           <= cnt_d;
			active_valid_q  <= active_valid_d;
			active_q        <= active_d;
			pending_valid_q <= pending_valid_d;
			pending_q       <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_freq_q   <= active_d.freq;
			out_buzzer_q <= phase_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.tone_freq_out = out_freq_q;
	assign result.buzzer_on     = out_buzzer_q;

	// The result register always shows the state left by the latest request.
	`BPS_ASSERT(a_result_tracks_state, clk, arst_n,
		accept |=> (out_buzzer_q == phase_q) && (out_freq_q == active_q.freq))

	// A command request never moves the phase or the counter.
	`BPS_ASSERT(a_cmd_keeps_phase, clk, arst_n,
		(accept && is_cmd) |=> $stable(phase_q) && $stable(cnt_q))

	// The buzzer only switches on for an active pattern.
	`BPS_ASSERT(a_on_needs_active, clk, arst_n,
		$rose(phase_q) |-> active_valid_q && $past(active_valid_q))

	// The on phase is only ever held with an active pattern behind it.
	`BPS_ASSERT_ALWAYS(a_phase_implies_active, clk, arst_n,
		!phase_q || active_valid_q)

endmodule
